[src/vlr_pkg.sv]
package vlr_pkg;

    localparam int COMP_W      = 32;                   // vector component width
    localparam int SQ_W        = 64;                   // square / sum width
    localparam int ROOT_W      = 32;                   // integer root width
    localparam int REM_W       = ROOT_W + 2;           // partial remainder, <= 2*root
    localparam int LEN_W       = 31;                   // rounded length width
    localparam int ROOT_STEPS  = 4;                    // root bits resolved per stage
    localparam int ROOT_STAGES = ROOT_W / ROOT_STEPS;  // root pipeline depth

    // Working set of the digit-by-digit square root, carried stage to stage.
    typedef struct packed {
        logic [SQ_W-1:0]   radicand;  // bits not yet consumed, MSB first
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root_state;

endpackage

[src/vlr_sum_squares.sv]
module vlr_sum_squares
    import vlr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [COMP_W-1:0] i_x,
    input  logic signed [COMP_W-1:0] i_y,
    input  logic signed [COMP_W-1:0] i_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SQ_W-1:0]          o_scaled
);

    // stage A: three squares
    logic            r_valid_a;
    logic [SQ_W-1:0] r_sq_x;
    logic [SQ_W-1:0] r_sq_y;
    logic [SQ_W-1:0] r_sq_z;
    logic            ready_a;
    logic [SQ_W-1:0] n_sq_x;
    logic [SQ_W-1:0] n_sq_y;
    logic [SQ_W-1:0] n_sq_z;

    // stage B: sum, times four
    logic            r_valid_b;
    logic [SQ_W-1:0] r_scaled;
    logic            ready_b;
    logic [SQ_W-1:0] n_sum;
    logic [SQ_W-1:0] n_scaled;

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign o_ready = ready_a;

    // signed 32x32 products; a square is non-negative and fits 63 bits
    assign n_sq_x = SQ_W'($signed(i_x) * $signed(i_x));
    assign n_sq_y = SQ_W'($signed(i_y) * $signed(i_y));
    assign n_sq_z = SQ_W'($signed(i_z) * $signed(i_z));

    assign n_sum    = r_sq_x + r_sq_y + r_sq_z;
    assign n_scaled = {n_sum[SQ_W-3:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_sq_x <= n_sq_x;
            r_sq_y <= n_sq_y;
            r_sq_z <= n_sq_z;
        end
        if (ready_b && r_valid_a) begin
            r_scaled <= n_scaled;
        end
    end

    assign o_valid  = r_valid_b;
    assign o_scaled = r_scaled;

endmodule

[src/vlr_root_stage.sv]
module vlr_root_stage
    import vlr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_root_state i_state,
    output logic        o_valid,
    input  logic        i_ready,
    output t_root_state o_state
);

    logic             r_valid;
    t_root_state      r_state;
    t_root_state      n_state;
    logic [SQ_W-1:0]  rad;
    logic [REM_W+1:0] rem_w;
    logic [REM_W+1:0] trial;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0] rem;

    assign o_ready = !r_valid || i_ready;

    // ROOT_STEPS iterations of the restoring square root, one root bit each
    always_comb begin
        rad   = i_state.radicand;
        rem   = i_state.rem;
        root  = i_state.root;
        rem_w = '0;
        trial = '0;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            root  = {root[ROOT_W-2:0], 1'b0};
            rem_w = {rem, rad[SQ_W-1 -: 2]};
            rad   = {rad[SQ_W-3:0], 2'b00};
            trial = (REM_W+2)'({root, 1'b1});
            if (rem_w >= trial) begin
                rem_w   = rem_w - trial;
                root[0] = 1'b1;
            end
            rem = rem_w[REM_W-1:0];
        end
        n_state.radicand = rad;
        n_state.rem      = rem;
        n_state.root     = root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

`ifndef NO_ASSERTIONS
    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state.rem <= REM_W'({r_state.root, 1'b0})))
        else $error("root stage remainder out of bound");

    // a held request stays in the stage while downstream stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_state))
        else $error("root stage dropped or altered a stalled request");

    // an accepted request shows up in the stage next cycle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_valid)
        else $error("root stage lost an accepted request");
`endif

endmodule

[src/vector3_length_rounded_isqrt.sv]
// Rounded length of a 3-vector: ((isqrt(4 * (x^2 + y^2 + z^2)) + 1) >> 1), all mod-2^n wrapped.
// Pipeline: 2 square/sum, 8 root and 1 rounding stage from request accept to o_valid.
// Throughput: one request per cycle unless stalled; each stage holds its own valid bit and takes
// a new request whenever it is empty or its contents move on, so bubbles collapse under stalls.
// Reset: synchronous, active low; clears all valid bits, the datapath is not reset.
module vector3_length_rounded_isqrt
    import vlr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [COMP_W-1:0] i_x_component,
    input  logic signed [COMP_W-1:0] i_y_component,
    input  logic signed [COMP_W-1:0] i_z_component,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [LEN_W-1:0]         o_length
);

    // Hand-off points between stages: index 0 is the scaled sum of squares,
    // index ROOT_STAGES holds the finished root.
    logic            stg_valid [ROOT_STAGES+1];
    logic            stg_ready [ROOT_STAGES+1];
    t_root_state     stg_state [ROOT_STAGES+1];
    logic [SQ_W-1:0] scaled;

    // Output register with its rounding step.
    logic              r_out_valid;
    logic [LEN_W-1:0]  r_length;
    logic              out_ready;
    logic [ROOT_W-1:0] n_bumped;

    // Squares, then sum shifted left by two (two register stages).
    vlr_sum_squares u_sum_squares (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_x      (i_x_component),
        .i_y      (i_y_component),
        .i_z      (i_z_component),
        .o_valid  (stg_valid[0]),
        .i_ready  (stg_ready[0]),
        .o_scaled (scaled)
    );

    // The root starts with the whole radicand and an empty remainder.
    assign stg_state[0].radicand = scaled;
    assign stg_state[0].rem      = '0;
    assign stg_state[0].root     = '0;

    // Root pipeline: each stage resolves ROOT_STEPS bits of the 32-bit root.
    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
        vlr_root_stage u_root_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_state (stg_state[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_state (stg_state[g+1])
        );
    end

    // Round to nearest: add one (wraps at 2^32, so an all-ones root gives zero), halve.
    assign out_ready                = !r_out_valid || i_ready;
    assign stg_ready[ROOT_STAGES]   = out_ready;
    assign n_bumped                 = stg_state[ROOT_STAGES].root + ROOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= stg_valid[ROOT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && stg_valid[ROOT_STAGES]) begin
            r_length <= n_bumped[ROOT_W-1:1];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_length = r_length;

endmodule
